// File: rtl/lfba_pkg.sv
package lfba_pkg;

    localparam int NUM_BLOCKS = 64;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int BLOCK_W  = $clog2(NUM_BLOCKS);
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_REQ  = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT_STEP,
        CMD_A_READ,
        CMD_A_TAKE,
        CMD_A_LINK,
        CMD_R_START,
        CMD_R_WB,
        CMD_F_STEP,
        CMD_F_SPLICE,
        CMD_RES_ALLOC,
        CMD_RES_DONE,
        CMD_RES_NOSPACE,
        CMD_RES_BAD
    } lfba_cmd_t;

    typedef struct packed {
        logic            head_valid;
        logic            cur_valid;
        logic            rdata_valid;
        logic            cnt_zero;
        logic            cnt_last;
        logic            init_last;
        logic            roll_more;
        logic            walk_more;
        logic            start_valid;
        logic [OP_W-1:0] op;
    } lfba_stat_t;

endpackage

// File: rtl/lfba_req_if.sv
interface lfba_req_if;
    logic                         valid;
    logic                         ready;
    logic [lfba_pkg::OP_W-1:0]    op;
    logic [lfba_pkg::COUNT_W-1:0] count;
    logic [lfba_pkg::BLOCK_W-1:0] start_block;

    modport source (output valid, output op, output count, output start_block, input ready);
    modport sink (input valid, input op, input count, input start_block, output ready);
endinterface

// File: rtl/lfba_rsp_if.sv
interface lfba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lfba_pkg::STATUS_W-1:0] status;
    logic [lfba_pkg::BLOCK_W-1:0]  first_block;

    modport source (output valid, output status, output first_block, input ready);
    modport sink (input valid, input status, input first_block, output ready);
endinterface

// File: rtl/lfba_ram.sv
module lfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lfba_datapath.sv
module lfba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfba_pkg::lfba_cmd_t           cmd,
    input  logic [lfba_pkg::OP_W-1:0]     in_op,
    input  logic [lfba_pkg::COUNT_W-1:0]  in_count,
    input  logic [lfba_pkg::BLOCK_W-1:0]  in_start,
    output lfba_pkg::lfba_stat_t          stat,
    output logic [lfba_pkg::STATUS_W-1:0] res_status,
    output logic [lfba_pkg::BLOCK_W-1:0]  res_first
);

    localparam int NUM_BLOCKS = lfba_pkg::NUM_BLOCKS;
    localparam int BW   = $clog2(NUM_BLOCKS);
    localparam int LW   = $clog2(NUM_BLOCKS + 1);
    localparam int CMPW = (LW > lfba_pkg::BLOCK_W) ? LW : lfba_pkg::BLOCK_W;
    localparam logic [LW-1:0] NONE = LW'(NUM_BLOCKS);

    logic [lfba_pkg::OP_W-1:0]     op_reg;
    logic [lfba_pkg::COUNT_W-1:0]  cnt_reg;
    logic [lfba_pkg::BLOCK_W-1:0]  start_reg;
    logic [LW-1:0]                 head_reg;
    logic [LW-1:0]                 cur_reg;
    logic [LW-1:0]                 prev_reg;
    logic [LW-1:0]                 first_reg;
    logic [LW-1:0]                 step_reg;
    logic [lfba_pkg::STATUS_W-1:0] status_reg;
    logic [lfba_pkg::BLOCK_W-1:0]  res_first_reg;

    logic          ram_we;
    logic [BW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [BW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;
    logic          rdata_ok;
    logic          prev_ok;

    function automatic logic is_blk(input logic [LW-1:0] v);
        return v < NONE;
    endfunction

    assign rdata_ok = is_blk(ram_rdata);
    assign prev_ok  = is_blk(prev_reg);

    lfba_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = (cmd == lfba_pkg::CMD_A_READ) ? head_reg[BW-1:0] : cur_reg[BW-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg[BW-1:0];
        ram_wdata = head_reg;
        case (cmd)
            lfba_pkg::CMD_INIT_STEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = step_reg[BW-1:0];
                ram_wdata = (step_reg == LW'(NUM_BLOCKS - 1)) ? NONE : step_reg + LW'(1);
            end
            lfba_pkg::CMD_A_TAKE:
            begin
                ram_we    = 1'b1;
                ram_wdata = NONE;
            end
            lfba_pkg::CMD_A_LINK:
            begin
                ram_we    = prev_ok;
                ram_waddr = prev_reg[BW-1:0];
                ram_wdata = cur_reg;
            end
            lfba_pkg::CMD_R_WB, lfba_pkg::CMD_F_SPLICE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= '0;
            cnt_reg       <= '0;
            start_reg     <= '0;
            head_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= NONE;
            first_reg     <= NONE;
            step_reg      <= '0;
            status_reg    <= lfba_pkg::STATUS_DONE;
            res_first_reg <= '0;
        end
        else
        begin
            case (cmd)
                lfba_pkg::CMD_INIT_STEP:
                begin
                    step_reg <= step_reg + LW'(1);
                    head_reg <= '0;
                end
                lfba_pkg::CMD_LOAD:
                begin
                    op_reg    <= in_op;
                    cnt_reg   <= in_count;
                    start_reg <= in_start;
                    cur_reg   <= LW'(in_start);
                    prev_reg  <= NONE;
                    first_reg <= NONE;
                    step_reg  <= '0;
                end
                lfba_pkg::CMD_A_READ:
                begin
                    cur_reg <= head_reg;
                end
                lfba_pkg::CMD_A_TAKE:
                begin
                    head_reg <= rdata_ok ? ram_rdata : NONE;
                end
                lfba_pkg::CMD_A_LINK:
                begin
                    if (!prev_ok)
                    begin
                        first_reg <= cur_reg;
                    end
                    prev_reg <= cur_reg;
                    cnt_reg  <= cnt_reg - lfba_pkg::COUNT_W'(1);
                end
                lfba_pkg::CMD_R_START:
                begin
                    cur_reg  <= first_reg;
                    step_reg <= '0;
                end
                lfba_pkg::CMD_R_WB:
                begin
                    head_reg <= cur_reg;
                    cur_reg  <= rdata_ok ? ram_rdata : NONE;
                    step_reg <= step_reg + LW'(1);
                end
                lfba_pkg::CMD_F_STEP:
                begin
                    cur_reg  <= ram_rdata;
                    step_reg <= step_reg + LW'(1);
                end
                lfba_pkg::CMD_F_SPLICE:
                begin
                    head_reg      <= LW'(start_reg);
                    status_reg    <= lfba_pkg::STATUS_DONE;
                    res_first_reg <= '0;
                end
                lfba_pkg::CMD_RES_ALLOC:
                begin
                    status_reg    <= lfba_pkg::STATUS_DONE;
                    res_first_reg <= first_reg[BW-1:0];
                end
                lfba_pkg::CMD_RES_DONE:
                begin
                    status_reg    <= lfba_pkg::STATUS_DONE;
                    res_first_reg <= '0;
                end
                lfba_pkg::CMD_RES_NOSPACE:
                begin
                    status_reg    <= lfba_pkg::STATUS_NO_SPACE;
                    res_first_reg <= '0;
                end
                lfba_pkg::CMD_RES_BAD:
                begin
                    status_reg    <= lfba_pkg::STATUS_BAD_REQ;
                    res_first_reg <= '0;
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    assign stat.head_valid  = is_blk(head_reg);
    assign stat.cur_valid   = is_blk(cur_reg);
    assign stat.rdata_valid = rdata_ok;
    assign stat.cnt_zero    = (cnt_reg == '0);
    assign stat.cnt_last    = (cnt_reg == lfba_pkg::COUNT_W'(1));
    assign stat.init_last   = (step_reg == LW'(NUM_BLOCKS - 1));
    assign stat.roll_more   = (step_reg < NONE);
    assign stat.walk_more   = (step_reg < LW'(NUM_BLOCKS - 1));
    assign stat.start_valid = (CMPW'(start_reg) < CMPW'(NUM_BLOCKS));
    assign stat.op          = op_reg;

    assign res_status = status_reg;
    assign res_first  = res_first_reg;

endmodule

// File: rtl/lfba_ctrl.sv
module lfba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lfba_pkg::lfba_stat_t stat,
    output lfba_pkg::lfba_cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_INIT   = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_DECODE = 14'b00000000000100,
        ST_A_TAKE = 14'b00000000001000,
        ST_A_WAIT = 14'b00000000010000,
        ST_A_LINK = 14'b00000000100000,
        ST_A_DONE = 14'b00000001000000,
        ST_R_RD   = 14'b00000010000000,
        ST_R_WB   = 14'b00000100000000,
        ST_F_RD   = 14'b00001000000000,
        ST_F_CHK  = 14'b00010000000000,
        ST_F_WR   = 14'b00100000000000,
        ST_REINIT = 14'b01000000000000,
        ST_RESP   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);

    always_comb
    begin
        state_next = state_reg;
        cmd        = lfba_pkg::CMD_NONE;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd = lfba_pkg::CMD_INIT_STEP;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = lfba_pkg::CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    lfba_pkg::OP_ALLOC:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd        = lfba_pkg::CMD_RES_BAD;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_A_TAKE;
                        end
                    end
                    lfba_pkg::OP_FREE:
                    begin
                        if (stat.start_valid)
                        begin
                            state_next = ST_F_RD;
                        end
                        else
                        begin
                            cmd        = lfba_pkg::CMD_RES_BAD;
                            state_next = ST_RESP;
                        end
                    end
                    lfba_pkg::OP_REINIT:
                    begin
                        cmd        = lfba_pkg::CMD_RES_DONE;
                        state_next = ST_REINIT;
                    end
                    default:
                    begin
                        cmd        = lfba_pkg::CMD_RES_BAD;
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_A_TAKE:
            begin
                if (stat.head_valid)
                begin
                    cmd        = lfba_pkg::CMD_A_READ;
                    state_next = ST_A_WAIT;
                end
                else
                begin
                    cmd        = lfba_pkg::CMD_R_START;
                    state_next = ST_R_RD;
                end
            end
            ST_A_WAIT:
            begin
                cmd        = lfba_pkg::CMD_A_TAKE;
                state_next = ST_A_LINK;
            end
            ST_A_LINK:
            begin
                cmd        = lfba_pkg::CMD_A_LINK;
                state_next = stat.cnt_last ? ST_A_DONE : ST_A_TAKE;
            end
            ST_A_DONE:
            begin
                cmd        = lfba_pkg::CMD_RES_ALLOC;
                state_next = ST_RESP;
            end
            ST_R_RD:
            begin
                if (stat.cur_valid && stat.roll_more)
                begin
                    state_next = ST_R_WB;
                end
                else
                begin
                    cmd        = lfba_pkg::CMD_RES_NOSPACE;
                    state_next = ST_RESP;
                end
            end
            ST_R_WB:
            begin
                cmd        = lfba_pkg::CMD_R_WB;
                state_next = ST_R_RD;
            end
            ST_F_RD:
            begin
                state_next = stat.walk_more ? ST_F_CHK : ST_F_WR;
            end
            ST_F_CHK:
            begin
                if (stat.rdata_valid)
                begin
                    cmd        = lfba_pkg::CMD_F_STEP;
                    state_next = ST_F_RD;
                end
                else
                begin
                    state_next = ST_F_WR;
                end
            end
            ST_F_WR:
            begin
                cmd        = lfba_pkg::CMD_F_SPLICE;
                state_next = ST_RESP;
            end
            ST_REINIT:
            begin
                cmd = lfba_pkg::CMD_INIT_STEP;
                if (stat.init_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/linked_free_list_block_allocator.sv
// Channel  Dir  Payload                            Transfer when
// req      in   op[1:0] count[6:0] start_block[5:0] req.valid & req.ready
// rsp      out  status[1:0] first_block[5:0]       rsp.valid & rsp.ready
//
// One request at a time; link table is one RAM with a write port and a registered read port.
// Allocate takes blocks off the head in turn; if the list runs dry it puts the taken
// blocks back and answers out of space. Free walks up to NUM_BLOCKS-1 links and splices
// the chain onto the head. Reinitialize sweeps the table. A zero count or unknown op
// gets bad request. After reset the link table is swept; req.ready stays low meanwhile.
// The response holds in its register until taken; no new request meanwhile.
module linked_free_list_block_allocator (
    input logic        clk,
    input logic        rst_n,
    lfba_req_if.sink   req,
    lfba_rsp_if.source rsp
);

    lfba_pkg::lfba_cmd_t  cmd;
    lfba_pkg::lfba_stat_t stat;

    lfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfba_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_op      (req.op),
        .in_count   (req.count),
        .in_start   (req.start_block),
        .stat       (stat),
        .res_status (rsp.status),
        .res_first  (rsp.first_block)
    );

endmodule
